@@ design/olq_pkg.sv @@
// Shared types and constants for the ordered list deque.
// Op codes, status codes and the control structs used between modules.
// No dependencies.
package olq_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int DATA_W    = 32;
    localparam int LEN_W     = 6;
    localparam int OP_W      = 3;

    typedef enum logic [OP_W-1:0] {
        OP_ADD_FRONT = 3'd0,
        OP_ADD_BACK  = 3'd1,
        OP_POP_FRONT = 3'd2,
        OP_POP_BACK  = 3'd3,
        OP_CLEAR     = 3'd4,
        OP_DELETE    = 3'd5,
        OP_READ_ALL  = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    typedef struct packed {
        logic    valid;
        t_status status;
        logic    last;
    } t_res;

endpackage

@@ design/olq_mem.sv @@
// Entry store of the ordered list deque: one write port, one read port,
// read data registered. Depends on olq_pkg.
module olq_mem
    import olq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                       i_clk,
    input  t_mem_ctl                   i_ctl,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [DATA_W-1:0]          i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [DATA_W-1:0]          o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/olq_ctrl.sv @@
// Command sequencer of the ordered list deque: front pointer, entry count,
// store walk for delete and readout, result registers. Depends on olq_pkg.
module olq_ctrl
    import olq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [OP_W-1:0]              i_op,
    input  logic signed [DATA_W-1:0]     i_value,
    output logic                         o_busy,
    output t_mem_ctl                     o_mem_ctl,
    output logic [$clog2(DEPTH)-1:0]     o_waddr,
    output logic [DATA_W-1:0]            o_wdata,
    output logic [$clog2(DEPTH)-1:0]     o_raddr,
    input  logic [DATA_W-1:0]            i_rdata,
    output t_res                         o_res,
    output logic signed [DATA_W-1:0]     o_data,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [IW-1:0] TOP_IDX = IW'(DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_POP  = 4'b0100,
        S_WALK = 4'b1000
    } t_state;

    function automatic logic [IW-1:0] f_slot(input logic [IW-1:0] base,
                                             input logic [CW-1:0] pos);
        logic [CW:0] sum;
        sum = {{(CW + 1 - IW){1'b0}}, base} + {1'b0, pos};
        if (sum >= (CW + 1)'(DEPTH)) begin
            sum = sum - (CW + 1)'(DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    t_state            r_state, n_state;
    logic [OP_W-1:0]   r_op, n_op;
    logic [DATA_W-1:0] r_value, n_value;
    logic [IW-1:0]     r_front, n_front;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_pos, n_pos;
    logic [CW-1:0]     r_cpos, n_cpos;
    logic              r_dv, n_dv;
    logic              r_found, n_found;
    t_res              r_res, n_res;
    logic [DATA_W-1:0] r_data, n_data;

    logic          is_full, is_empty, last_pos, hit;
    logic [IW-1:0] front_dec, front_inc;

    assign is_full   = (r_count >= DEPTH_C);
    assign is_empty  = (r_count == '0);
    assign front_dec = (r_front == '0) ? TOP_IDX : r_front - 1'b1;
    assign front_inc = (r_front == TOP_IDX) ? '0 : r_front + 1'b1;
    assign last_pos  = (r_cpos == r_count - 1'b1);
    assign hit       = (i_rdata == r_value);

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_value   = r_value;
        n_front   = r_front;
        n_count   = r_count;
        n_pos     = r_pos;
        n_cpos    = r_cpos;
        n_dv      = r_dv;
        n_found   = r_found;
        n_res     = '{valid: 1'b0, status: ST_OK, last: 1'b1};
        n_data    = '0;
        o_mem_ctl = '{wr_en: 1'b0, rd_en: 1'b0};
        o_waddr   = '0;
        o_wdata   = r_value;
        o_raddr   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op    = i_op;
                    n_value = i_value;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                unique case (r_op)
                    OP_ADD_FRONT: begin
                        n_res.valid = 1'b1;
                        if (is_full) begin
                            n_res.status = ST_FULL;
                        end else begin
                            n_front         = front_dec;
                            o_waddr         = front_dec;
                            o_mem_ctl.wr_en = 1'b1;
                            n_count         = r_count + 1'b1;
                        end
                    end
                    OP_ADD_BACK: begin
                        n_res.valid = 1'b1;
                        if (is_full) begin
                            n_res.status = ST_FULL;
                        end else begin
                            o_waddr         = f_slot(r_front, r_count);
                            o_mem_ctl.wr_en = 1'b1;
                            n_count         = r_count + 1'b1;
                        end
                    end
                    OP_POP_FRONT, OP_POP_BACK: begin
                        if (is_empty) begin
                            n_res.valid  = 1'b1;
                            n_res.status = ST_EMPTY;
                        end else begin
                            o_mem_ctl.rd_en = 1'b1;
                            o_raddr = (r_op == OP_POP_FRONT) ? r_front
                                    : f_slot(r_front, r_count - 1'b1);
                            n_state = S_POP;
                        end
                    end
                    OP_CLEAR: begin
                        n_res.valid = 1'b1;
                        n_count     = '0;
                        n_front     = '0;
                    end
                    OP_DELETE, OP_READ_ALL: begin
                        if (is_empty) begin
                            n_res.valid  = 1'b1;
                            n_res.status = ST_EMPTY;
                        end else begin
                            n_pos   = '0;
                            n_dv    = 1'b0;
                            n_found = 1'b0;
                            n_state = S_WALK;
                        end
                    end
                    default: begin
                        n_res.valid = 1'b1;
                    end
                endcase
            end
            S_POP: begin
                n_res.valid = 1'b1;
                n_data      = i_rdata;
                n_count     = r_count - 1'b1;
                if (r_op == OP_POP_FRONT) begin
                    n_front = front_inc;
                end
                n_state = S_IDLE;
            end
            S_WALK: begin
                // reads run one entry ahead of compare and shift-down writes
                if (r_pos != r_count) begin
                    o_mem_ctl.rd_en = 1'b1;
                    o_raddr = f_slot(r_front, r_pos);
                    n_pos   = r_pos + 1'b1;
                    n_cpos  = r_pos;
                    n_dv    = 1'b1;
                end else begin
                    n_dv = 1'b0;
                end
                if (r_dv) begin
                    if (r_op == OP_READ_ALL) begin
                        n_res.valid = 1'b1;
                        n_res.last  = last_pos;
                        n_data      = i_rdata;
                    end else begin
                        if (r_found) begin
                            o_mem_ctl.wr_en = 1'b1;
                            o_waddr = f_slot(r_front, r_cpos - 1'b1);
                            o_wdata = i_rdata;
                        end else if (hit) begin
                            n_found = 1'b1;
                        end
                        if (last_pos) begin
                            n_res.valid = 1'b1;
                            if (r_found || hit) begin
                                n_data  = r_value;
                                n_count = r_count - 1'b1;
                            end else begin
                                n_res.status = ST_NOTFOUND;
                            end
                        end
                    end
                    if (last_pos) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_count <= '0;
            r_dv    <= 1'b0;
            r_found <= 1'b0;
            r_res   <= '{valid: 1'b0, status: ST_OK, last: 1'b0};
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            r_dv    <= n_dv;
            r_found <= n_found;
            r_res   <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_value <= n_value;
        r_pos   <= n_pos;
        r_cpos  <= n_cpos;
        r_data  <= n_data;
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_res   = r_res;
    assign o_data  = r_data;
    assign o_count = r_count;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count beyond depth");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res.valid && r_res.last |-> r_state == S_IDLE)
        else $error("final result while a command is still running");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> r_state == S_EXEC)
        else $error("accepted transaction not executed");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_ctl.wr_en && o_mem_ctl.rd_en |-> o_waddr != o_raddr)
        else $error("read and write to the same entry in one cycle");

    a_walk_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK && r_dv |-> r_pos == r_cpos + 1'b1)
        else $error("walk read pointer out of step");
`endif

endmodule

@@ design/ordered_list_deque_with_delete_top.sv @@
// Top level of the ordered list deque with delete by value.
// Instantiates olq_ctrl and olq_mem; depends on olq_pkg.
//
// Usage:
//   A command (i_op, i_value) is taken at a rising edge with start high and
//   busy low. Results come back on o_status, o_data_out, o_length, o_last,
//   each valid for exactly one cycle while o_valid is high; o_last marks the
//   final result of a command. The receiver cannot stall the block.
// Command sequence:
//   Add, clear, unused codes and commands on an empty list: the result is
//   registered in the execute state; the next command waits for busy low.
//   Pops: the execute state issues the store read, the pop state returns it.
//   Delete and readout: the single read port walks one entry per cycle,
//   so readout strobes one result per cycle and delete compacts later
//   entries during the same walk.
// Reset:
//   Synchronous, active low. Length and front pointer clear to zero at once;
//   the entry store is not cleared, there is no clearing pass.
module ordered_list_deque_with_delete_top
    import olq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [OP_W-1:0]           i_op,
    input  logic signed [DATA_W-1:0]  i_value,
    output logic                      o_valid,
    output logic [1:0]                o_status,
    output logic signed [DATA_W-1:0]  o_data_out,
    output logic [LEN_W-1:0]          o_length,
    output logic                      o_last
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_mem_ctl             mem_ctl;
    logic [IW-1:0]        waddr, raddr;
    logic [DATA_W-1:0]    wdata, rdata;
    t_res                 res;
    logic [CW-1:0]        count;
    logic [LEN_W+CW-1:0]  count_ext;

    olq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_op      (i_op),
        .i_value   (i_value),
        .o_busy    (busy),
        .o_mem_ctl (mem_ctl),
        .o_waddr   (waddr),
        .o_wdata   (wdata),
        .o_raddr   (raddr),
        .i_rdata   (rdata),
        .o_res     (res),
        .o_data    (o_data_out),
        .o_count   (count)
    );

    olq_mem #(.DEPTH(DEPTH)) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // length reported modulo 64
    assign count_ext = {{LEN_W{1'b0}}, count};
    assign o_length  = count_ext[LEN_W-1:0];
    assign o_valid   = res.valid;
    assign o_status  = res.status;
    assign o_last    = res.last;

endmodule
